>>> hw/rtl/sea_pkg.sv
// ----------------------------------------------------------------------------
// sea_pkg: shared types, constants and helpers for the epipolar angle unit
// Fixed-point formats, pipeline depths, register map, arctangent table and
// the one-digit square root step used by both square root pipelines.
// ----------------------------------------------------------------------------
package sea_pkg;

  localparam int FRACTION_BITS = 16;
  localparam int ANGLE_BITS    = 30;
  localparam int ANGLE_UP      = ANGLE_BITS - FRACTION_BITS;
  localparam int CORDIC_STEPS  = 30;

  // square root digit steps, divider steps
  localparam int TSQ_STEPS = 31;
  localparam int DIV_STEPS = 18;
  localparam int ASQ_STEPS = 17;

  localparam int FRONT_STAGES = 5;
  localparam int TERM_STAGES  = 3 + TSQ_STEPS + 1 + DIV_STEPS;
  localparam int ASIN_STAGES  = 2 + ASQ_STEPS + CORDIC_STEPS + 1;
  localparam int TOTAL_LAT    = FRONT_STAGES + TERM_STAGES + 1 + ASIN_STAGES;

  localparam int HALF_PI_Q30 = 1686629713;
  localparam int HALF_PI_OUT = (HALF_PI_Q30 + (1 << (ANGLE_UP - 1))) >> ANGLE_UP;
  localparam int OUT_MAX     = 'h1FFFF;
  localparam int TERM_LIM    = 1 << (FRACTION_BITS + 1);
  localparam int S_ONE       = 1 << FRACTION_BITS;

  typedef logic signed [17:0] fix_t;
  typedef logic signed [19:0] tcomp_t;
  typedef logic signed [38:0] cross_t;
  typedef logic signed [58:0] dot_t;
  typedef logic [17:0]        term_t;
  typedef logic [16:0]        sval_t;
  typedef logic [16:0]        angle_t;
  typedef logic [53:0]        row_t;
  typedef logic [59:0]        trans_t;

  // register map
  localparam logic [2:0] REG_ROT0  = 3'd0;
  localparam logic [2:0] REG_ROT1  = 3'd1;
  localparam logic [2:0] REG_ROT2  = 3'd2;
  localparam logic [2:0] REG_TRANS = 3'd3;

  localparam row_t   ROT0_RESET  = row_t'(1) << (36 + FRACTION_BITS);
  localparam row_t   ROT1_RESET  = row_t'(1) << (18 + FRACTION_BITS);
  localparam row_t   ROT2_RESET  = row_t'(1) << FRACTION_BITS;
  localparam trans_t TRANS_RESET = trans_t'(1) << 40;

  // atan(2^-i), Q30, truncated
  localparam logic [29:0] ATAN_Q30 [CORDIC_STEPS] = '{
    30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76,
    30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD,
    30'h000FFFFF, 30'h0007FFFF, 30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF,
    30'h00007FFF, 30'h00003FFF, 30'h00001FFF, 30'h00000FFF, 30'h000007FF,
    30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F, 30'h0000003F,
    30'h0000001F, 30'h0000000F, 30'h00000008, 30'h00000004, 30'h00000002
  };

  typedef struct packed {
    logic [33:0] rem;
    logic [30:0] root;
  } sq_t;

  // one result bit of floor(sqrt), consuming the next two radicand bits
  function automatic sq_t sq_step(sq_t cur, logic [1:0] pair);
    logic [33:0] acc;
    logic [33:0] trial;
    sq_t         res;
    acc   = {cur.rem[31:0], pair};
    trial = {1'b0, cur.root, 2'b01};
    if (acc >= trial) begin
      res.rem  = acc - trial;
      res.root = {cur.root[29:0], 1'b1};
    end else begin
      res.rem  = acc;
      res.root = {cur.root[29:0], 1'b0};
    end
    return res;
  endfunction

endpackage

>>> hw/rtl/sea_term.sv
// ----------------------------------------------------------------------------
// sea_term: pipelined plane term |d| / |c|
// Scales c into 30 bits, forms |c| by a bit-per-stage square root, then a
// bit-per-stage restoring divider; saturates at 2.0, zero when c is zero.
// ----------------------------------------------------------------------------
module sea_term (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  sea_pkg::cross_t c_x,
  input  sea_pkg::cross_t c_y,
  input  sea_pkg::cross_t c_z,
  input  sea_pkg::dot_t   d,
  output logic           out_valid,
  output sea_pkg::term_t  term
);
  import sea_pkg::*;

  typedef struct packed {
    logic zero;
    logic sat;
  } div_flags_t;

  logic [TERM_STAGES-1:0] vld_r;

  cross_t      c [3];
  logic [37:0] m [3];
  logic [37:0] mx;
  logic [3:0]  k;
  logic [57:0] dmag;

  logic [29:0] ms_r  [3];
  logic [59:0] sqr_r [3];
  logic [57:0] dk1_r, dk2_r, dk3_r;
  logic [61:0] v3_r;

  sq_t         sq_r  [TSQ_STEPS];
  logic [61:0] vq_r  [TSQ_STEPS];
  logic [57:0] dkq_r [TSQ_STEPS];

  logic [30:0] n_c;
  logic [30:0] n0_r;
  logic [48:0] rem0_r;
  div_flags_t  fl0_r;

  logic [48:0] rem_r [DIV_STEPS];
  term_t       q_r   [DIV_STEPS];
  logic [30:0] nd_r  [DIV_STEPS];
  div_flags_t  fl_r  [DIV_STEPS];

  assign c[0] = c_x;
  assign c[1] = c_y;
  assign c[2] = c_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[TERM_STAGES-2:0], in_valid};
    end
  end

  // shift so that every component stays below 2^30
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m[i] = c[i][38] ? 38'(-c[i]) : 38'(c[i]);
    end
    mx = m[0];
    if (m[1] > mx) mx = m[1];
    if (m[2] > mx) mx = m[2];
    k = '0;
    for (int j = 8; j >= 0; j--) begin
      if ((mx >> j) < 38'(1 << 30)) k = 4'(j);
    end
    dmag = d[58] ? 58'(-d) : 58'(d);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      ms_r[i]  <= 30'(m[i] >> k);
      sqr_r[i] <= ms_r[i] * ms_r[i];
    end
    dk1_r <= dmag >> k;
    dk2_r <= dk1_r;
    dk3_r <= dk2_r;
    v3_r  <= 62'(sqr_r[0]) + 62'(sqr_r[1]) + 62'(sqr_r[2]);
  end

  for (genvar s = 0; s < TSQ_STEPS; s++) begin : g_sq
    if (s == 0) begin : g_first
      always_ff @(posedge clk) begin
        sq_r[s]  <= sq_step(sq_t'('0), v3_r[61:60]);
        vq_r[s]  <= v3_r;
        dkq_r[s] <= dk3_r;
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        sq_r[s]  <= sq_step(sq_r[s-1], vq_r[s-1][61-2*s -: 2]);
        vq_r[s]  <= vq_r[s-1];
        dkq_r[s] <= dkq_r[s-1];
      end
    end
  end

  assign n_c = sq_r[TSQ_STEPS-1].root;

  // quotient must fit 18 bits, otherwise it is past the limit anyway
  always_ff @(posedge clk) begin
    n0_r      <= n_c;
    rem0_r    <= dkq_r[TSQ_STEPS-1][48:0];
    fl0_r.zero <= (n_c == '0);
    fl0_r.sat  <= (dkq_r[TSQ_STEPS-1] >= {9'b0, n_c, 18'b0});
  end

  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
    logic [48:0] rin;
    logic [47:0] dsh;
    term_t       qin;
    logic [30:0] nin;
    div_flags_t  fin;
    if (s == 0) begin : g_first
      assign rin = rem0_r;
      assign qin = '0;
      assign nin = n0_r;
      assign fin = fl0_r;
    end else begin : g_next
      assign rin = rem_r[s-1];
      assign qin = q_r[s-1];
      assign nin = nd_r[s-1];
      assign fin = fl_r[s-1];
    end
    assign dsh = {17'b0, nin} << (DIV_STEPS - 1 - s);
    always_ff @(posedge clk) begin
      nd_r[s] <= nin;
      fl_r[s] <= fin;
      if (rin >= {1'b0, dsh}) begin
        rem_r[s] <= rin - {1'b0, dsh};
        q_r[s]   <= qin | (term_t'(1) << (DIV_STEPS - 1 - s));
      end else begin
        rem_r[s] <= rin;
        q_r[s]   <= qin;
      end
    end
  end

  always_comb begin
    if (fl_r[DIV_STEPS-1].zero) begin
      term = '0;
    end else if (fl_r[DIV_STEPS-1].sat || (q_r[DIV_STEPS-1] > term_t'(TERM_LIM))) begin
      term = term_t'(TERM_LIM);
    end else begin
      term = q_r[DIV_STEPS-1];
    end
  end

  assign out_valid = vld_r[TERM_STAGES-1];

endmodule

>>> hw/rtl/sea_asin.sv
// ----------------------------------------------------------------------------
// sea_asin: pipelined arcsine of s in [0,1]
// x = sqrt(1 - s^2) by a bit-per-stage square root, then a 30-stage
// vectoring CORDIC on (x, s); angle rounded to the output format.
// ----------------------------------------------------------------------------
module sea_asin (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  sea_pkg::sval_t  s,
  output logic           out_valid,
  output sea_pkg::angle_t angle
);
  import sea_pkg::*;

  logic [ASIN_STAGES-1:0] vld_r;

  logic [32:0] s2_r;
  logic [32:0] va_r;
  sval_t       sa1_r, sa2_r;

  sq_t         sq_r  [ASQ_STEPS];
  logic [33:0] vq_r  [ASQ_STEPS];
  sval_t       sq_s_r [ASQ_STEPS];

  logic signed [33:0] x_r [CORDIC_STEPS];
  logic signed [33:0] y_r [CORDIC_STEPS];
  logic signed [33:0] z_r [CORDIC_STEPS];

  logic signed [33:0] zf;
  logic [19:0]        r;
  angle_t             angle_nxt;
  angle_t             angle_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[ASIN_STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    s2_r  <= 33'(s) * 33'(s);
    sa1_r <= s;
    va_r  <= (33'(1) << (2 * FRACTION_BITS)) - s2_r;
    sa2_r <= sa1_r;
  end

  for (genvar p = 0; p < ASQ_STEPS; p++) begin : g_sq
    if (p == 0) begin : g_first
      always_ff @(posedge clk) begin
        sq_r[p]   <= sq_step(sq_t'('0), 2'(va_r[32]));
        vq_r[p]   <= {1'b0, va_r};
        sq_s_r[p] <= sa2_r;
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        sq_r[p]   <= sq_step(sq_r[p-1], vq_r[p-1][33-2*p -: 2]);
        vq_r[p]   <= vq_r[p-1];
        sq_s_r[p] <= sq_s_r[p-1];
      end
    end
  end

  for (genvar c = 0; c < CORDIC_STEPS; c++) begin : g_cordic
    logic signed [33:0] xi, yi, zi, xs, ys, at;
    if (c == 0) begin : g_first
      assign xi = $signed(34'(sq_r[ASQ_STEPS-1].root[16:0]) << ANGLE_UP);
      assign yi = $signed(34'(sq_s_r[ASQ_STEPS-1]) << ANGLE_UP);
      assign zi = '0;
    end else begin : g_next
      assign xi = x_r[c-1];
      assign yi = y_r[c-1];
      assign zi = z_r[c-1];
    end
    assign xs = xi >>> c;
    assign ys = yi >>> c;
    assign at = $signed({4'b0, ATAN_Q30[c]});
    always_ff @(posedge clk) begin
      if (!yi[33]) begin
        x_r[c] <= xi + ys;
        y_r[c] <= yi - xs;
        z_r[c] <= zi + at;
      end else begin
        x_r[c] <= xi - ys;
        y_r[c] <= yi + xs;
        z_r[c] <= zi - at;
      end
    end
  end

  always_comb begin
    zf = z_r[CORDIC_STEPS-1];
    if (zf[33]) begin
      r = '0;
    end else begin
      r = 20'((zf + (34'sd1 <<< (ANGLE_UP - 1))) >>> ANGLE_UP);
    end
    if (r > 20'(HALF_PI_OUT)) r = 20'(HALF_PI_OUT);
    if (r > 20'(OUT_MAX)) begin
      angle_nxt = angle_t'(OUT_MAX);
    end else begin
      angle_nxt = r[16:0];
    end
  end

  always_ff @(posedge clk) begin
    angle_r <= angle_nxt;
  end

  assign angle     = angle_r;
  assign out_valid = vld_r[ASIN_STAGES-1];

endmodule

>>> hw/rtl/symmetric_epipolar_angle_unit.sv
// ----------------------------------------------------------------------------
// symmetric_epipolar_angle_unit: symmetric epipolar angle of a bearing pair
// Rotates b2 into view one, forms both epipolar plane normals, averages the
// two normalised plane distances and returns their arcsine.
//
//   channel  handshake              beat
//   in_      start & !busy          b1 (first_*), b2 (second_*), Q1.16
//   out_     out_valid (strobe)     epipolar_angle, unsigned Q1.16 rad
//   cfg_     cfg_valid & cfg_ready  cfg_index, cfg_data
//
// One pair per clock. Depth is set by the 31-step square root and 18-step
// divider of the plane terms and by the 17-step square root and 30-step
// CORDIC of the arcsine. busy stays low and cfg_ready stays high. Reset
// clears the valid pipeline and loads identity rotation and translation
// (1,0,0).
// ----------------------------------------------------------------------------
module symmetric_epipolar_angle_unit (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  sea_pkg::fix_t    in_first_x,
  input  sea_pkg::fix_t    in_first_y,
  input  sea_pkg::fix_t    in_first_z,
  input  sea_pkg::fix_t    in_second_x,
  input  sea_pkg::fix_t    in_second_y,
  input  sea_pkg::fix_t    in_second_z,
  output logic            out_valid,
  output sea_pkg::angle_t  out_epipolar_angle,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [2:0]      cfg_index,
  input  logic [59:0]     cfg_data
);
  import sea_pkg::*;

  row_t   rot0_r, rot1_r, rot2_r;
  trans_t trans_r;

  row_t   rows [3];
  fix_t   rmat [3][3];
  tcomp_t tv   [3];
  fix_t   b1   [3];
  fix_t   b2   [3];

  logic [FRONT_STAGES-1:0] vld_r;

  logic signed [35:0] prod_r [3][3];
  fix_t               b1_1_r [3];
  fix_t               b1_2_r [3];
  fix_t               b2w_r  [3];
  fix_t               b2w_nxt [3];
  fix_t               b1_3_r [3];
  fix_t               b2w_3_r [3];
  cross_t             c1_r   [3];
  cross_t             c2_r   [3];
  logic signed [56:0] dp1_r  [3];
  logic signed [56:0] dp2_r  [3];
  cross_t             c1_4_r [3];
  cross_t             c2_4_r [3];
  cross_t             c1_5_r [3];
  cross_t             c2_5_r [3];
  dot_t               d1_r, d2_r;

  logic  t1_valid, t2_valid;
  term_t term1, term2;

  logic [18:0] tsum;
  logic [17:0] half;
  sval_t       s_nxt;
  sval_t       s_r;
  logic        sv_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot0_r  <= ROT0_RESET;
      rot1_r  <= ROT1_RESET;
      rot2_r  <= ROT2_RESET;
      trans_r <= TRANS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ROT0:  rot0_r  <= cfg_data[53:0];
        REG_ROT1:  rot1_r  <= cfg_data[53:0];
        REG_ROT2:  rot2_r  <= cfg_data[53:0];
        REG_TRANS: trans_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign rows[0] = rot0_r;
  assign rows[1] = rot1_r;
  assign rows[2] = rot2_r;
  assign b1[0] = in_first_x;
  assign b1[1] = in_first_y;
  assign b1[2] = in_first_z;
  assign b2[0] = in_second_x;
  assign b2[1] = in_second_y;
  assign b2[2] = in_second_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        rmat[i][j] = rows[i][53-18*j -: 18];
      end
      tv[i] = trans_r[59-20*i -: 20];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[FRONT_STAGES-2:0], start && !busy};
    end
  end

  // stage 1: R * b2 partial products
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_r[i][j] <= rmat[i][j] * b2[j];
      end
      b1_1_r[i] <= b1[i];
    end
  end

  // stage 2: round half up, saturate to 18 bits
  always_comb begin
    logic signed [37:0] acc;
    logic signed [21:0] rnd;
    for (int i = 0; i < 3; i++) begin
      acc = 38'(prod_r[i][0]) + 38'(prod_r[i][1]) + 38'(prod_r[i][2]);
      rnd = 22'((acc + (38'sd1 <<< (FRACTION_BITS - 1))) >>> FRACTION_BITS);
      if (rnd > 22'sd131071) begin
        b2w_nxt[i] = 18'sh1FFFF;
      end else if (rnd < -22'sd131072) begin
        b2w_nxt[i] = 18'sh20000;
      end else begin
        b2w_nxt[i] = rnd[17:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      b2w_r[i]  <= b2w_nxt[i];
      b1_2_r[i] <= b1_1_r[i];
    end
  end

  // stage 3: plane normals t x b1, t x b2w
  always_ff @(posedge clk) begin
    c1_r[0] <= tv[1] * b1_2_r[2] - tv[2] * b1_2_r[1];
    c1_r[1] <= tv[2] * b1_2_r[0] - tv[0] * b1_2_r[2];
    c1_r[2] <= tv[0] * b1_2_r[1] - tv[1] * b1_2_r[0];
    c2_r[0] <= tv[1] * b2w_r[2] - tv[2] * b2w_r[1];
    c2_r[1] <= tv[2] * b2w_r[0] - tv[0] * b2w_r[2];
    c2_r[2] <= tv[0] * b2w_r[1] - tv[1] * b2w_r[0];
    for (int i = 0; i < 3; i++) begin
      b1_3_r[i]  <= b1_2_r[i];
      b2w_3_r[i] <= b2w_r[i];
    end
  end

  // stages 4 and 5: dot products c1.b2w and c2.b1
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      dp1_r[i]  <= c1_r[i] * b2w_3_r[i];
      dp2_r[i]  <= c2_r[i] * b1_3_r[i];
      c1_4_r[i] <= c1_r[i];
      c2_4_r[i] <= c2_r[i];
      c1_5_r[i] <= c1_4_r[i];
      c2_5_r[i] <= c2_4_r[i];
    end
    d1_r <= 59'(dp1_r[0]) + 59'(dp1_r[1]) + 59'(dp1_r[2]);
    d2_r <= 59'(dp2_r[0]) + 59'(dp2_r[1]) + 59'(dp2_r[2]);
  end

  sea_term u_term1 (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vld_r[FRONT_STAGES-1]),
    .c_x       (c1_5_r[0]),
    .c_y       (c1_5_r[1]),
    .c_z       (c1_5_r[2]),
    .d         (d1_r),
    .out_valid (t1_valid),
    .term      (term1)
  );

  sea_term u_term2 (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vld_r[FRONT_STAGES-1]),
    .c_x       (c2_5_r[0]),
    .c_y       (c2_5_r[1]),
    .c_z       (c2_5_r[2]),
    .d         (d2_r),
    .out_valid (t2_valid),
    .term      (term2)
  );

  always_comb begin
    tsum = 19'(term1) + 19'(term2);
    half = tsum[18:1];
    if (half > 18'(S_ONE)) begin
      s_nxt = sval_t'(S_ONE);
    end else begin
      s_nxt = half[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r <= 1'b0;
    end else begin
      sv_r <= t1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s_r <= s_nxt;
  end

  sea_asin u_asin (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sv_r),
    .s         (s_r),
    .out_valid (out_valid),
    .angle     (out_epipolar_angle)
  );

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, TOTAL_LAT))
    else $error("result beat without a matching accepted item");

  a_lanes: assert property (@(posedge clk) disable iff (!rst_n)
    t1_valid == t2_valid)
    else $error("plane term lanes out of step");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_epipolar_angle <= angle_t'(HALF_PI_OUT)))
    else $error("angle beyond half pi");

endmodule
